// ----- rtl/lph_pkg.sv -----
// ----------------------------------------------------------------------------
// lph_pkg
// Shared widths, codes, hash constants and controller/datapath link types
// for the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

	localparam int LOG2_SLOTS_DEF = 10;
	localparam int KEY_W          = 64;
	localparam int REQ_W          = 2;
	localparam int STATUS_W       = 3;
	localparam int SLOT_W         = 10;
	localparam int TOTAL_W        = 11;
	localparam int CAP_W          = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 4;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd10;

	// fmix64 constants
	localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int               MIX_SH = 33;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NEW      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STORE    = 1'd1;

	typedef struct packed {
		logic clr_init;
		logic clr_step;
		logic load;
		logic hash_go;
		logic probe_init;
		logic probe_step;
		logic probe_end;
		logic act;
		logic rd_scan;
		logic scan_take;
		logic scan_put;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic slot_free;
		logic key_eq;
		logic probe_last;
		logic scan_needed;
		logic scan_stop;
	} ctrl_sts_t;

endpackage

// ----- rtl/lph_ram.sv -----
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lph_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/lph_hash.sv -----
// ----------------------------------------------------------------------------
// lph_hash
// Iterative fmix64: each 64-bit multiply is built from three 32x32 partial
// products on one shared multiplier, one per cycle.
// ----------------------------------------------------------------------------
module lph_hash (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [lph_pkg::KEY_W-1:0] din,
	output logic                     done,
	output logic [lph_pkg::KEY_W-1:0] dout
);

	localparam logic [3:0] STEP_IDLE = 4'd0;
	localparam logic [3:0] STEP_MIX1 = 4'd4;
	localparam logic [3:0] STEP_FIN  = 4'd8;

	logic [3:0]                step_q;
	logic                      done_q;
	logic [lph_pkg::KEY_W-1:0] x_q;
	logic [lph_pkg::KEY_W-1:0] acc_q;
	logic [lph_pkg::KEY_W-1:0] mc;
	logic [31:0]               op_a;
	logic [31:0]               op_b;
	logic [63:0]               prod;
	logic [63:0]               addend;

	// pick the partial product for this step
	always_comb begin
		mc   = (step_q < STEP_MIX1) ? lph_pkg::MIX_C1 : lph_pkg::MIX_C2;
		op_a = x_q[31:0];
		op_b = mc[31:0];
		case (step_q[1:0])
			2'd2: op_a = x_q[63:32];
			2'd3: op_b = mc[63:32];
			default: ;
		endcase
		prod   = {32'b0, op_a} * {32'b0, op_b};
		addend = (step_q[1:0] == 2'd1) ? prod : {prod[31:0], 32'b0};
	end

	// advance the mixing sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				step_q <= 4'd1;
			end else if (step_q == STEP_FIN) begin
				step_q <= STEP_IDLE;
				done_q <= 1'b1;
			end else if (step_q != STEP_IDLE) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// datapath of the mix
	always_ff @(posedge clk) begin
		if (go) begin
			x_q   <= din ^ (din >> lph_pkg::MIX_SH);
			acc_q <= '0;
		end else if (step_q == STEP_MIX1 || step_q == STEP_FIN) begin
			x_q   <= acc_q ^ (acc_q >> lph_pkg::MIX_SH);
			acc_q <= '0;
		end else if (step_q != STEP_IDLE) begin
			acc_q <= acc_q + addend;
		end
	end

	assign done = done_q;
	assign dout = x_q;

endmodule

// ----- rtl/lph_datapath.sv -----
// ----------------------------------------------------------------------------
// lph_datapath
// Slot stores, probe and scan counters, config registers and result registers.
// ----------------------------------------------------------------------------
module lph_datapath #(
	parameter int LOG2_SLOTS = lph_pkg::LOG2_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lph_pkg::ctrl_cmd_t              cmd,
	output lph_pkg::ctrl_sts_t              sts,
	input  logic                            cfg_we,
	input  logic [lph_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lph_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [lph_pkg::REQ_W-1:0]       req_type,
	input  logic [lph_pkg::KEY_W-1:0]       key,
	input  logic [lph_pkg::KEY_W-1:0]       value_in,
	output logic [lph_pkg::STATUS_W-1:0]    status,
	output logic [lph_pkg::KEY_W-1:0]       value_out,
	output logic [lph_pkg::SLOT_W-1:0]      slot_index,
	output logic [lph_pkg::TOTAL_W-1:0]     entry_total
);

	localparam int L     = LOG2_SLOTS;
	localparam int DEPTH = 1 << LOG2_SLOTS;
	localparam int KW    = lph_pkg::KEY_W;

	logic [lph_pkg::CAP_W-1:0]    cap_q;
	logic                         sv_q;
	logic [lph_pkg::CAP_W-1:0]    lg;
	logic [L-1:0]                 mask;
	logic [lph_pkg::REQ_W-1:0]    req_q;
	logic [KW-1:0]                pkey_q;
	logic [KW-1:0]                val_q;
	logic [KW-1:0]                mv_q;
	logic [KW-1:0]                vfound_q;
	logic [L-1:0]                 pi_q;
	logic [L-1:0]                 pn_q;
	logic [L-1:0]                 sj_q;
	logic [L-1:0]                 sn_q;
	logic [L-1:0]                 clr_q;
	logic [L:0]                   cnt_q;
	logic                         met_q;
	logic                         hit_q;
	logic [lph_pkg::STATUS_W-1:0] status_q;
	logic [KW-1:0]                vout_q;
	logic [L-1:0]                 slot_q;
	logic                         is_ins;
	logic                         is_rem;
	logic                         kw_en;
	logic [L-1:0]                 kw_addr;
	logic [KW:0]                  kw_data;
	logic                         vw_en;
	logic [KW-1:0]                vw_data;
	logic [L-1:0]                 raddr;
	logic [KW:0]                  kr_data;
	logic [KW-1:0]                vr_data;
	logic                         hash_done;
	logic [KW-1:0]                hash_out;
	logic [KW-1:0]                hash_in;

	// clamp capacity and build the slot mask
	always_comb begin
		lg = cap_q;
		if (cap_q == '0) begin
			lg = 4'd1;
		end else if (cap_q > L) begin
			lg = lph_pkg::CAP_W'(L);
		end
		mask = ~({L{1'b1}} << lg);
	end

	assign is_ins = (req_q == lph_pkg::REQ_INSERT);
	assign is_rem = (req_q == lph_pkg::REQ_REMOVE);

	// key store write select: clear, action, scan take-out, scan put-back
	always_comb begin
		kw_en   = 1'b0;
		kw_addr = pi_q;
		kw_data = {1'b0, pkey_q};
		if (cmd.clr_step) begin
			kw_en   = 1'b1;
			kw_addr = clr_q;
			kw_data = '0;
		end else if (cmd.scan_take) begin
			kw_en   = 1'b1;
			kw_addr = sj_q;
			kw_data = {1'b0, kr_data[KW-1:0]};
		end else if (cmd.scan_put) begin
			kw_en   = 1'b1;
			kw_data = {1'b1, pkey_q};
		end else if (cmd.act) begin
			kw_en   = (is_ins && met_q && !hit_q) || (is_rem && hit_q);
			kw_data = {is_ins, pkey_q};
		end
	end

	// value store write select
	always_comb begin
		vw_en   = 1'b0;
		vw_data = val_q;
		if (cmd.scan_put) begin
			vw_en   = 1'b1;
			vw_data = mv_q;
		end else if (cmd.act) begin
			vw_en   = is_ins && met_q && sv_q;
		end
	end

	assign raddr   = cmd.rd_scan ? sj_q : pi_q;
	assign hash_in = cmd.load ? key : kr_data[KW-1:0];

	lph_ram #(
		.WIDTH (KW + 1),
		.DEPTH (DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (kw_en),
		.waddr (kw_addr),
		.wdata (kw_data),
		.raddr (raddr),
		.rdata (kr_data)
	);

	lph_ram #(
		.WIDTH (KW),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (vw_en),
		.waddr (pi_q),
		.wdata (vw_data),
		.raddr (raddr),
		.rdata (vr_data)
	);

	lph_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.hash_go),
		.din    (hash_in),
		.done   (hash_done),
		.dout   (hash_out)
	);

	// status back to the controller
	always_comb begin
		sts.clr_last    = (clr_q == L'(DEPTH - 1));
		sts.hash_done   = hash_done;
		sts.slot_free   = !kr_data[KW];
		sts.key_eq      = kr_data[KW] && (kr_data[KW-1:0] == pkey_q);
		sts.probe_last  = (pn_q == mask);
		sts.scan_needed = is_rem && hit_q;
		sts.scan_stop   = !kr_data[KW] || (sn_q == mask);
	end

	// config registers, clear counter and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lph_pkg::CAP_RESET;
			sv_q  <= 1'b1;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we && cfg_index == lph_pkg::REG_CAPACITY) begin
				cap_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == lph_pkg::REG_STORE) begin
				sv_q <= cfg_wdata[0];
			end
			if (cmd.clr_init) begin
				clr_q <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.clr_step) begin
					clr_q <= clr_q + 1'b1;
				end
				if (cmd.act && is_ins && met_q && !hit_q) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (cmd.act && is_rem && hit_q) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// request, probe and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			pkey_q <= key;
			val_q  <= value_in;
		end
		if (cmd.scan_take) begin
			pkey_q <= kr_data[KW-1:0];
			mv_q   <= vr_data;
		end
		if (cmd.probe_init) begin
			pi_q <= hash_out[L-1:0] & mask;
			pn_q <= '0;
		end else if (cmd.probe_step) begin
			pi_q <= (pi_q + 1'b1) & mask;
			pn_q <= pn_q + 1'b1;
		end
		if (cmd.probe_end) begin
			met_q    <= !kr_data[KW] || (kr_data[KW-1:0] == pkey_q);
			hit_q    <= kr_data[KW] && (kr_data[KW-1:0] == pkey_q);
			vfound_q <= vr_data;
		end
		if (cmd.act && is_rem && hit_q) begin
			sj_q <= (pi_q + 1'b1) & mask;
			sn_q <= '0;
		end else if (cmd.scan_put) begin
			sj_q <= (sj_q + 1'b1) & mask;
			sn_q <= sn_q + 1'b1;
		end
	end

	// result of the request
	always_ff @(posedge clk) begin
		if (cmd.act) begin
			status_q <= lph_pkg::ST_NOTFOUND;
			slot_q   <= '0;
			vout_q   <= '0;
			if (is_ins) begin
				if (hit_q) begin
					status_q <= lph_pkg::ST_UPDATED;
					slot_q   <= pi_q;
				end else if (met_q) begin
					status_q <= lph_pkg::ST_NEW;
					slot_q   <= pi_q;
				end else begin
					status_q <= lph_pkg::ST_FULL;
				end
			end else if (hit_q) begin
				status_q <= lph_pkg::ST_FOUND;
				slot_q   <= pi_q;
				if (!is_rem && sv_q) begin
					vout_q <= vfound_q;
				end
			end
		end
	end

	assign status      = status_q;
	assign value_out   = vout_q;
	assign slot_index  = lph_pkg::SLOT_W'(slot_q);
	assign entry_total = lph_pkg::TOTAL_W'(cnt_q);

endmodule

// ----- rtl/lph_ctrl.sv -----
// ----------------------------------------------------------------------------
// lph_ctrl
// Request sequencer: clearing sweep, hash, probe, action and the
// re-insertion scan that follows a remove that hits.
// ----------------------------------------------------------------------------
module lph_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          cfg_we,
	input  logic [lph_pkg::CFG_IDX_W-1:0] cfg_index,
	input  lph_pkg::ctrl_sts_t            sts,
	output lph_pkg::ctrl_cmd_t            cmd,
	output logic                          busy,
	output logic                          done
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_P_RD, S_P_CMP, S_ACT,
		S_R_RD, S_R_CMP, S_HASH2, S_Q_RD, S_Q_CMP
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   cap_wr;
	logic   probe_hit;

	assign cap_wr    = cfg_we && (cfg_index == lph_pkg::REG_CAPACITY);
	assign probe_hit = sts.slot_free || sts.key_eq || sts.probe_last;

	// commands for the current state
	always_comb begin
		cmd          = '0;
		cmd.clr_init = cap_wr;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				cmd.load    = start && !cap_wr;
				cmd.hash_go = start && !cap_wr;
			end
			S_HASH, S_HASH2: cmd.probe_init = sts.hash_done;
			S_P_CMP: begin
				cmd.probe_end  = probe_hit;
				cmd.probe_step = !probe_hit;
			end
			S_ACT: cmd.act = 1'b1;
			S_R_RD: cmd.rd_scan = 1'b1;
			S_R_CMP: begin
				cmd.rd_scan   = 1'b1;
				cmd.scan_take = !sts.scan_stop;
				cmd.hash_go   = !sts.scan_stop;
			end
			S_Q_CMP: begin
				cmd.scan_put   = probe_hit;
				cmd.probe_step = !probe_hit;
			end
			default: ;
		endcase
	end

	// state and response strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cap_wr) begin
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: if (sts.clr_last) state_q <= S_IDLE;
					S_IDLE:  if (start) state_q <= S_HASH;
					S_HASH:  if (sts.hash_done) state_q <= S_P_RD;
					S_P_RD:  state_q <= S_P_CMP;
					S_P_CMP: state_q <= probe_hit ? S_ACT : S_P_RD;
					S_ACT: begin
						if (sts.scan_needed) begin
							state_q <= S_R_RD;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
					S_R_RD:  state_q <= S_R_CMP;
					S_R_CMP: begin
						if (sts.scan_stop) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_HASH2;
						end
					end
					S_HASH2: if (sts.hash_done) state_q <= S_Q_RD;
					S_Q_RD:  state_q <= S_Q_CMP;
					S_Q_CMP: state_q <= probe_hit ? S_R_RD : S_Q_RD;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// a response only follows the action or the end of a scan
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_ACT || state_q == S_R_CMP))
		else $error("response without a finished request");

	// an accepted item starts the hash
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && !cap_wr) |=> state_q == S_HASH)
		else $error("accepted item did not start hashing");

	// never step past the last slot of a full pass
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_step |-> !sts.probe_last)
		else $error("probe stepped beyond one pass");

	// at most one key store writer per cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.scan_take, cmd.scan_put, cmd.act}))
		else $error("key store write conflict");

endmodule

// ----- rtl/linear_probe_hash_table_top.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing key/value table with linear probing and fmix64 start slot.
// ----------------------------------------------------------------------------
// After reset and after every write of capacity_log2 the table runs a
// clearing sweep over all 2^LOG2_SLOTS slots with busy high. A request is
// taken when start is high and busy low; its result is valid on the output
// ports while done is high, for exactly one cycle, and the receiver cannot
// stall it. A lookup or insert first hashes the key, whose two 64-bit
// multiplies run as three 32x32 partial products each on one multiplier,
// and then probes slots, each probed slot costing a read and a compare on
// the slot RAM. A remove that hits also rehashes and re-places every entry
// of the cluster behind it. The user must write configuration only while
// busy is low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
	parameter int LOG2_SLOTS = lph_pkg::LOG2_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [lph_pkg::REQ_W-1:0]      req_type,
	input  logic [lph_pkg::KEY_W-1:0]      key,
	input  logic [lph_pkg::KEY_W-1:0]      value_in,
	output logic                           done,
	output logic [lph_pkg::STATUS_W-1:0]   status,
	output logic [lph_pkg::KEY_W-1:0]      value_out,
	output logic [lph_pkg::SLOT_W-1:0]     slot_index,
	output logic [lph_pkg::TOTAL_W-1:0]    entry_total,
	input  logic                           cfg_we,
	input  logic [lph_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lph_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	lph_pkg::ctrl_cmd_t cmd;
	lph_pkg::ctrl_sts_t sts;

	lph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	lph_datapath #(
		.LOG2_SLOTS (LOG2_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req_type),
		.key         (key),
		.value_in    (value_in),
		.status      (status),
		.value_out   (value_out),
		.slot_index  (slot_index),
		.entry_total (entry_total)
	);

endmodule
